### rtl/emergency_drain_supervisor_top_assert.svh
// assertion macros shared by the emergency drain supervisor rtl
`ifndef EMERGENCY_DRAIN_SUPERVISOR_TOP_ASSERT_SVH
`define EMERGENCY_DRAIN_SUPERVISOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define EDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/eds_pkg.sv
// shared types and constants of the emergency drain supervisor
`default_nettype none

package eds_pkg;

	// configuration register width and reset values
	localparam int unsigned CFG_WIDTH = 18;
	localparam logic [CFG_WIDTH-1:0] QUALIFY_RST = 18'd3000;
	localparam logic [CFG_WIDTH-1:0] MAX_DRAIN_RST = 18'd180000;
	localparam logic [CFG_WIDTH-1:0] EXTRA_DRAIN_RST = 18'd5000;
	localparam logic [CFG_WIDTH-1:0] WINDOW_HOLD_RST = 18'd20000;

	// register indexes
	localparam int unsigned CFG_IDX_WIDTH = 2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_QUALIFY = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_DRAIN = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_EXTRA_DRAIN = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_HOLD = 2'd3;

	// phase codes
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_QUAL = 3'd1,
		PH_DRAIN = 3'd2,
		PH_FINISHING = 3'd3,
		PH_FINISHED = 3'd4,
		PH_WAIT_CLEAR = 3'd5
	} phase_t;

	// configuration bundle
	typedef struct packed {
		logic [CFG_WIDTH-1:0] qualify_ticks;
		logic [CFG_WIDTH-1:0] max_drain_ticks;
		logic [CFG_WIDTH-1:0] extra_drain_ticks;
		logic [CFG_WIDTH-1:0] window_hold_ticks;
	} cfg_t;

	// phase machine state after the current tick
	typedef struct packed {
		logic active;
		phase_t phase;
	} phase_res_t;

endpackage

`default_nettype wire

### rtl/eds_cfg_regs.sv
// configuration register file of the emergency drain supervisor
`default_nettype none

module eds_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [eds_pkg::CFG_IDX_WIDTH-1:0] wr_index,
	input wire logic [eds_pkg::CFG_WIDTH-1:0] wr_data,
	output eds_pkg::cfg_t cfg
);

	eds_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qualify_ticks <= eds_pkg::QUALIFY_RST;
			cfg_q.max_drain_ticks <= eds_pkg::MAX_DRAIN_RST;
			cfg_q.extra_drain_ticks <= eds_pkg::EXTRA_DRAIN_RST;
			cfg_q.window_hold_ticks <= eds_pkg::WINDOW_HOLD_RST;
		end else if (wr_en) begin
			case (wr_index)
				eds_pkg::REG_QUALIFY: cfg_q.qualify_ticks <= wr_data;
				eds_pkg::REG_MAX_DRAIN: cfg_q.max_drain_ticks <= wr_data;
				eds_pkg::REG_EXTRA_DRAIN: cfg_q.extra_drain_ticks <= wr_data;
				eds_pkg::REG_WINDOW_HOLD: cfg_q.window_hold_ticks <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/eds_phase_fsm.sv
// emergency drain phase machine with its saturating phase timer
`default_nettype none

module eds_phase_fsm #(
	parameter int unsigned TIMER_WIDTH = 18
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic cond,
	input wire logic empty,
	input wire eds_pkg::cfg_t cfg,
	output eds_pkg::phase_res_t res
);

	localparam int unsigned CW = (TIMER_WIDTH > eds_pkg::CFG_WIDTH) ?
		TIMER_WIDTH : eds_pkg::CFG_WIDTH;

	eds_pkg::phase_t phase_q, phase_d;
	logic active_q, active_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d, elapsed;
	logic [CW-1:0] elapsed_x;

	// state registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= eds_pkg::PH_IDLE;
			active_q <= 1'b0;
			timer_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			active_q <= active_d;
			timer_q <= timer_d;
		end
	end

	// saturating increment of the phase timer
	assign elapsed = (timer_q == '1) ? timer_q : timer_q + 1'b1;
	assign elapsed_x = CW'(elapsed);

	// next state
	always_comb begin
		phase_d = phase_q;
		active_d = active_q;
		timer_d = timer_q;
		case (phase_q)
			eds_pkg::PH_IDLE: begin
				if (cond) begin
					phase_d = eds_pkg::PH_QUAL;
					timer_d = '0;
				end
			end
			eds_pkg::PH_QUAL: begin
				timer_d = elapsed;
				if (!cond) begin
					phase_d = eds_pkg::PH_IDLE;
				end else if (elapsed_x >= CW'(cfg.qualify_ticks)) begin
					active_d = 1'b1;
					phase_d = eds_pkg::PH_DRAIN;
					timer_d = '0;
				end
			end
			eds_pkg::PH_DRAIN: begin
				timer_d = elapsed;
				if (empty || elapsed_x >= CW'(cfg.max_drain_ticks)) begin
					phase_d = eds_pkg::PH_FINISHING;
					timer_d = '0;
				end
			end
			eds_pkg::PH_FINISHING: begin
				timer_d = elapsed;
				if (elapsed_x >= CW'(cfg.extra_drain_ticks)) begin
					phase_d = eds_pkg::PH_FINISHED;
				end
			end
			eds_pkg::PH_FINISHED: begin
				active_d = 1'b0;
				phase_d = eds_pkg::PH_WAIT_CLEAR;
			end
			eds_pkg::PH_WAIT_CLEAR: begin
				if (!cond) begin
					phase_d = eds_pkg::PH_IDLE;
				end
			end
			default: phase_d = eds_pkg::PH_IDLE;
		endcase
	end

	assign res.active = active_d;
	assign res.phase = phase_d;

	`include "emergency_drain_supervisor_top_assert.svh"

	`EDS_ASSERT_NOW(a_drain_active, (phase_q == eds_pkg::PH_DRAIN), active_q, "draining without active flag")
	`EDS_ASSERT_NOW(a_idle_inactive, (phase_q == eds_pkg::PH_IDLE), !active_q, "idle with active flag")
	`EDS_ASSERT_NEXT(a_finished_once, (step && phase_q == eds_pkg::PH_FINISHED), (phase_q == eds_pkg::PH_WAIT_CLEAR && !active_q), "finished phase did not hand over to wait clear")
	`EDS_ASSERT_NEXT(a_hold_no_step, (!step), ($stable(phase_q) && $stable(timer_q)), "state moved without an accepted tick")

endmodule

`default_nettype wire

### rtl/eds_window.sv
// safe window tracker: continuous pump run timer and window age timer
`default_nettype none

module eds_window #(
	parameter int unsigned TIMER_WIDTH = 18
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic pump,
	input wire eds_pkg::cfg_t cfg,
	output logic window_next
);

	localparam int unsigned CW = (TIMER_WIDTH > eds_pkg::CFG_WIDTH) ?
		TIMER_WIDTH : eds_pkg::CFG_WIDTH;

	logic [TIMER_WIDTH-1:0] pump_timer_q, pump_timer_d, pump_inc;
	logic [TIMER_WIDTH-1:0] age_q, age_d, age_inc;
	logic window_q;
	logic refreshed;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_timer_q <= '0;
			age_q <= '0;
			window_q <= 1'b0;
		end else if (step) begin
			pump_timer_q <= pump_timer_d;
			age_q <= age_d;
			window_q <= window_next;
		end
	end

	// saturating increments
	assign pump_inc = (pump_timer_q == '1) ? pump_timer_q : pump_timer_q + 1'b1;
	assign age_inc = (age_q == '1) ? age_q : age_q + 1'b1;

	// pump run tracking and window refresh
	always_comb begin
		pump_timer_d = pump ? pump_inc : '0;
		refreshed = pump && (CW'(pump_inc) >= CW'(cfg.max_drain_ticks));
		age_d = refreshed ? '0 : age_inc;
		window_next = refreshed | window_q;
		if (CW'(age_d) >= CW'(cfg.window_hold_ticks)) begin
			window_next = 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/emergency_drain_supervisor_top.sv
// Emergency drain supervisor: one tick transaction is accepted per clock when the
// result register is free or being emptied in the same cycle. The phase machine and
// safe window tracker update in the cycle of acceptance and the result for that tick
// is presented from the result register on the next cycle. The sustained rate is one
// tick per clock; only a stalled result register holds off the tick input.
// Configuration writes are always ready and take effect on the next tick.
// TIMER_WIDTH (8 to 32) sets the saturating timer width.
`default_nettype none

module emergency_drain_supervisor_top #(
	parameter int unsigned TIMER_WIDTH = 18
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write channel
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [eds_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input wire logic [eds_pkg::CFG_WIDTH-1:0] cfg_data,
	// tick channel
	input wire logic tick_valid,
	output logic tick_stall,
	input wire logic door_locked,
	input wire logic level_safe,
	input wire logic level_empty,
	input wire logic pump_running,
	// result channel
	output logic res_valid,
	input wire logic res_stall,
	output logic drain_request,
	output logic drain_active,
	output logic window_open,
	output logic busy_res,
	output logic [2:0] phase
);

	eds_pkg::cfg_t cfg;
	eds_pkg::phase_res_t phase_res;
	logic step;
	logic window_next;
	logic busy_next;
	logic res_valid_q;
	logic active_q, window_q, busy_q;
	eds_pkg::phase_t phase_q;

	// handshakes
	assign cfg_ready = 1'b1;
	assign tick_stall = res_valid_q & res_stall;
	assign step = tick_valid & ~tick_stall;

	eds_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid & cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	eds_phase_fsm #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.cond(~door_locked & ~level_safe),
		.empty(level_empty),
		.cfg(cfg),
		.res(phase_res)
	);

	eds_window #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.pump(pump_running),
		.cfg(cfg),
		.window_next(window_next)
	);

	// busy unless idle or waiting for the condition to clear
	always_comb begin
		busy_next = !(phase_res.phase inside {eds_pkg::PH_IDLE, eds_pkg::PH_WAIT_CLEAR});
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			active_q <= phase_res.active;
			window_q <= window_next;
			busy_q <= busy_next;
			phase_q <= phase_res.phase;
		end
	end

	assign res_valid = res_valid_q;
	assign drain_request = active_q;
	assign drain_active = active_q;
	assign window_open = window_q;
	assign busy_res = busy_q;
	assign phase = phase_q;

endmodule

`default_nettype wire
